[rtl/bbwm_pkg.sv]
// Shared types, constants and codes of the box blur window mean unit.
package bbwm_pkg;

	// Field and register widths
	localparam int PIX_W      = 8;
	localparam int POS_W      = 8;
	localparam int DIM_W      = 9;
	localparam int RAD_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int RGB_W      = 3 * PIX_W;

	// Window sums: at most 15 * 15 pixels of 255
	localparam int SUM_W  = 16;
	localparam int AREA_W = 2 * RAD_W;
	localparam int STEP_W = $clog2(SUM_W);

	// Signed window coordinates, centre minus half radius up to that plus radius minus one
	localparam int COORD_W = 11;

	// Parameter defaults
	localparam int DEFAULT_MAX_WIDTH  = 256;
	localparam int DEFAULT_MAX_HEIGHT = 256;
	localparam int DEFAULT_MAX_RADIUS = 15;

	// Register reset values
	localparam logic [DIM_W-1:0] RESET_WIDTH  = 9'd256;
	localparam logic [DIM_W-1:0] RESET_HEIGHT = 9'd256;
	localparam logic [RAD_W-1:0] RESET_RADIUS = 4'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLUR_RADIUS  = 2'd2;

	// Item functions
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DIV_INIT,
		ST_DIVIDE,
		ST_DELIVER
	} bbwm_state_t;

	typedef struct packed {
		logic wr_en;     // store the incoming pixel
		logic start;     // latch a query centre, clear sums and counters
		logic scan;      // read the current window pixel, advance counters
		logic div_init;  // load the dividers from the sums
		logic div_step;  // one quotient bit per channel
		logic load_out;  // move the result into the output register
	} bbwm_cmd_t;

	typedef struct packed {
		logic bad_pos;   // incoming centre lies outside the image
		logic scan_last; // current pixel is the last of the window
		logic div_last;  // current divide step is the last one
	} bbwm_status_t;

endpackage

[rtl/bbwm_ram.sv]
// Generic simple dual port RAM with registered read data.
module bbwm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/bbwm_ctrl.sv]
// Controller state machine of the box blur window mean unit.
module bbwm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  func,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  bbwm_pkg::bbwm_status_t status,
	output bbwm_pkg::bbwm_cmd_t   cmd
);

	import bbwm_pkg::*;

	bbwm_state_t state_q, state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (func == FUNC_WRITE) begin
						cmd.wr_en = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = status.bad_pos ? ST_DELIVER : ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			// last read data is summed here
			ST_DRAIN: begin
				state_d = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_DELIVER;
				end
			end
			ST_DELIVER: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/bbwm_datapath.sv]
// Datapath: configuration, frame store, window scan, sums, dividers, result.
module bbwm_datapath #(
	parameter int MAX_WIDTH  = bbwm_pkg::DEFAULT_MAX_WIDTH,
	parameter int MAX_HEIGHT = bbwm_pkg::DEFAULT_MAX_HEIGHT,
	parameter int MAX_RADIUS = bbwm_pkg::DEFAULT_MAX_RADIUS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [bbwm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bbwm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [bbwm_pkg::POS_W-1:0]           column,
	input  logic [bbwm_pkg::POS_W-1:0]           row,
	input  logic [bbwm_pkg::PIX_W-1:0]           red_in,
	input  logic [bbwm_pkg::PIX_W-1:0]           green_in,
	input  logic [bbwm_pkg::PIX_W-1:0]           blue_in,
	input  bbwm_pkg::bbwm_cmd_t                  cmd,
	output bbwm_pkg::bbwm_status_t               status,
	output logic [bbwm_pkg::PIX_W-1:0]           red_out,
	output logic [bbwm_pkg::PIX_W-1:0]           green_out,
	output logic [bbwm_pkg::PIX_W-1:0]           blue_out,
	output logic                                 bad_position
);

	import bbwm_pkg::*;

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// configuration
	logic [DIM_W-1:0] width_q, height_q;
	logic [RAD_W-1:0] radius_q;
	logic [DIM_W-1:0] w_eff, h_eff;
	logic [RAD_W-1:0] rad_eff;

	// query and scan state
	logic [POS_W-1:0]   col_q, row_q;
	logic [RAD_W-1:0]   rad_q;
	logic [AREA_W-1:0]  area_q;
	logic               bad_q;
	logic [RAD_W-1:0]   i_cnt_q, j_cnt_q;
	logic               rd_pend_s1;
	logic [COORD_W-1:0] x, y;
	logic               in_win;

	// store
	logic              wr_ok;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [RGB_W-1:0]  rdata;

	// sums and dividers, channel 0 red, 1 green, 2 blue
	logic [SUM_W-1:0]  sum_q [3];
	logic [SUM_W-1:0]  num_q [3];
	logic [AREA_W-1:0] rem_q [3];
	logic [STEP_W-1:0] step_q;
	logic [AREA_W:0]   trial [3];
	logic              qbit  [3];
	logic [PIX_W-1:0]  pix   [3];

	always_comb begin
		w_eff = (32'(width_q) > 32'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
		h_eff = (32'(height_q) > 32'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;
		if (radius_q == '0) begin
			rad_eff = RAD_W'(1);
		end else if (32'(radius_q) > 32'(MAX_RADIUS)) begin
			rad_eff = RAD_W'(MAX_RADIUS);
		end else begin
			rad_eff = radius_q;
		end
	end

	assign status.bad_pos = (DIM_W'(column) >= w_eff) || (DIM_W'(row) >= h_eff);

	// window pixel under the scan counters
	assign x = COORD_W'(col_q) - COORD_W'(rad_q >> 1) + COORD_W'(j_cnt_q);
	assign y = COORD_W'(row_q) - COORD_W'(rad_q >> 1) + COORD_W'(i_cnt_q);
	assign in_win = !x[COORD_W-1] && !y[COORD_W-1]
		&& (x < COORD_W'(w_eff)) && (y < COORD_W'(h_eff));

	assign status.scan_last = (i_cnt_q == rad_q - RAD_W'(1))
		&& (j_cnt_q == rad_q - RAD_W'(1));
	assign status.div_last = (step_q == STEP_W'(SUM_W - 1));

	assign wr_ok = (32'(column) < 32'(MAX_WIDTH)) && (32'(row) < 32'(MAX_HEIGHT));
	assign waddr = ADDR_W'(32'(row) * 32'(MAX_WIDTH) + 32'(column));
	assign raddr = ADDR_W'(32'(y[COORD_W-2:0]) * 32'(MAX_WIDTH) + 32'(x[COORD_W-2:0]));

	bbwm_ram #(
		.WIDTH(RGB_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr_en && wr_ok),
		.waddr(waddr),
		.wdata({red_in, green_in, blue_in}),
		.re   (cmd.scan && in_win),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign pix[0] = rdata[3*PIX_W-1:2*PIX_W];
	assign pix[1] = rdata[2*PIX_W-1:PIX_W];
	assign pix[2] = rdata[PIX_W-1:0];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			trial[c] = {rem_q[c], num_q[c][SUM_W-1]};
			qbit[c]  = (trial[c] >= (AREA_W+1)'(area_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= RESET_WIDTH;
			height_q   <= RESET_HEIGHT;
			radius_q   <= RESET_RADIUS;
			rd_pend_s1 <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
					CFG_IMAGE_HEIGHT: height_q <= cfg_data;
					CFG_BLUR_RADIUS:  radius_q <= cfg_data[RAD_W-1:0];
					default: ;
				endcase
			end
			rd_pend_s1 <= cmd.scan && in_win;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			col_q   <= column;
			row_q   <= row;
			rad_q   <= rad_eff;
			area_q  <= AREA_W'(rad_eff * rad_eff);
			bad_q   <= status.bad_pos;
			i_cnt_q <= '0;
			j_cnt_q <= '0;
			for (int c = 0; c < 3; c++) begin
				sum_q[c] <= '0;
			end
		end else begin
			if (cmd.scan) begin
				if (j_cnt_q == rad_q - RAD_W'(1)) begin
					j_cnt_q <= '0;
					i_cnt_q <= i_cnt_q + RAD_W'(1);
				end else begin
					j_cnt_q <= j_cnt_q + RAD_W'(1);
				end
			end
			if (rd_pend_s1) begin
				for (int c = 0; c < 3; c++) begin
					sum_q[c] <= sum_q[c] + SUM_W'(pix[c]);
				end
			end
		end

		// restoring division, quotient shifts into the numerator register
		if (cmd.div_init) begin
			step_q <= '0;
			for (int c = 0; c < 3; c++) begin
				num_q[c] <= sum_q[c];
				rem_q[c] <= '0;
			end
		end else if (cmd.div_step) begin
			step_q <= step_q + STEP_W'(1);
			for (int c = 0; c < 3; c++) begin
				num_q[c] <= {num_q[c][SUM_W-2:0], qbit[c]};
				rem_q[c] <= qbit[c] ? AREA_W'(trial[c] - (AREA_W+1)'(area_q))
					: AREA_W'(trial[c]);
			end
		end

		if (cmd.load_out) begin
			bad_position <= bad_q;
			red_out      <= bad_q ? '0 : num_q[0][PIX_W-1:0];
			green_out    <= bad_q ? '0 : num_q[1][PIX_W-1:0];
			blue_out     <= bad_q ? '0 : num_q[2][PIX_W-1:0];
		end
	end

endmodule

[rtl/box_blur_window_mean_unit.sv]
// Top level of the box blur window mean unit.
//
// Input channel (in_valid/in_ready): func selects a pixel write or a query.
// A write stores red_in/green_in/blue_in at (column, row) and gives no
// result; a write beyond MAX_WIDTH x MAX_HEIGHT is dropped.
// A query returns one item on the output channel (out_valid/out_ready): the
// window sums over blur_radius x blur_radius in-image pixels, each divided
// by blur_radius squared. A centre outside the image returns zeros with
// bad_position set.
// A valid query scans each window pixel in turn, reading the frame store
// for those inside the image, then runs a 16-step restoring divider that
// does all three channels together.
// One item is worked on at a time; in_ready is high only while idle, so
// writes go back to back and a query holds in_ready low until it is done.
// The output register holds a result until taken, and a write or a new
// query is accepted meanwhile; a finished query waits for the slot to free.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready.
// Reset sets width 256, height 256, radius 3; the frame store is not cleared
// and must be written before it is read.
module box_blur_window_mean_unit #(
	parameter int MAX_WIDTH  = bbwm_pkg::DEFAULT_MAX_WIDTH,
	parameter int MAX_HEIGHT = bbwm_pkg::DEFAULT_MAX_HEIGHT,
	parameter int MAX_RADIUS = bbwm_pkg::DEFAULT_MAX_RADIUS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bbwm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bbwm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            func,
	input  logic [bbwm_pkg::POS_W-1:0]      column,
	input  logic [bbwm_pkg::POS_W-1:0]      row,
	input  logic [bbwm_pkg::PIX_W-1:0]      red_in,
	input  logic [bbwm_pkg::PIX_W-1:0]      green_in,
	input  logic [bbwm_pkg::PIX_W-1:0]      blue_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bbwm_pkg::PIX_W-1:0]      red_out,
	output logic [bbwm_pkg::PIX_W-1:0]      green_out,
	output logic [bbwm_pkg::PIX_W-1:0]      blue_out,
	output logic                            bad_position
);

	import bbwm_pkg::*;

	bbwm_cmd_t    cmd;
	bbwm_status_t status;

	assign cfg_ready = 1'b1;

	bbwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	bbwm_datapath #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_RADIUS(MAX_RADIUS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.column      (column),
		.row         (row),
		.red_in      (red_in),
		.green_in    (green_in),
		.blue_in     (blue_in),
		.cmd         (cmd),
		.status      (status),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out),
		.bad_position(bad_position)
	);

endmodule

[rtl/bbwm_checker.sv]
// Port-level assertions of the box blur window mean unit, bound to the top level.
module bbwm_props (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       func,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [bbwm_pkg::PIX_W-1:0] red_out,
	input logic [bbwm_pkg::PIX_W-1:0] green_out,
	input logic [bbwm_pkg::PIX_W-1:0] blue_out,
	input logic                       bad_position
);

	import bbwm_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red_out)
			&& $stable(green_out) && $stable(blue_out) && $stable(bad_position))
		else $error("result changed while stalled");

	// an off-image query carries zero pixel values
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_position |-> red_out == '0 && green_out == '0
			&& blue_out == '0)
		else $error("bad position result not zero");

	// a query keeps the input side busy for at least the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == FUNC_QUERY |=> !in_ready)
		else $error("input ready right after a query item");

endmodule

bind box_blur_window_mean_unit bbwm_props u_props (.*);
